### rtl/sont_pkg.sv
// Package for the spiking oscillator network tick block.
// Holds sizes, codes, controller/datapath structs and saturation helper.
// No dependencies.
`default_nettype none

package sont_pkg;

  localparam int NEURONS = 32;
  localparam int EDGES   = 256;
  localparam int GROUP   = 5;
  localparam int NI_W    = $clog2(NEURONS);
  localparam int EI_W    = $clog2(EDGES);
  localparam int IDX_W   = EI_W + 1;
  localparam int GI_W    = $clog2(2 * GROUP);

  typedef enum logic [1:0] {
    FUNC_LOAD_NEURON = 2'd0,
    FUNC_LOAD_EDGE   = 2'd1,
    FUNC_TICK        = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    REG_NEURON_COUNT = 3'd0,
    REG_EDGE_COUNT   = 3'd1,
    REG_INPUT_BASE   = 3'd2,
    REG_LEFT_BASE    = 3'd3,
    REG_RIGHT_BASE   = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N_RD,
    ST_N_WR,
    ST_E_RD,
    ST_E_OP,
    ST_E_MUL,
    ST_E_WR,
    ST_D_RD,
    ST_D_WR,
    ST_S_RD,
    ST_S_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e             op;
    logic [IDX_W-1:0]   idx;
    logic               accept;
    logic               out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

`default_nettype wire

### rtl/spiking_oscillator_network_tick.sv
// Top level: APB register file, controller and datapath of the network.
// Sequence: a load word goes straight to the done state; a tick runs a neuron pass
// (read, write), an edge pass (read, operand, multiply, write), drive and group-sum passes.
// One word is in flight; the next is taken once the result enters the output register.
// Reset: async active low; neuron state reads as zero until loaded, no sweep.
`default_nettype none

module spiking_oscillator_network_tick
  import sont_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [7:0]         slot_i,
  input  wire logic [11:0]        period_in_i,
  input  wire logic signed [11:0] spike_value_in_i,
  input  wire logic [11:0]        phase_in_i,
  input  wire logic [4:0]         source_in_i,
  input  wire logic [4:0]         target_in_i,
  input  wire logic signed [11:0] weight_in_i,
  input  wire logic [2:0]         drive_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [14:0]      left_sum_o,
  output logic signed [14:0]      right_sum_o,
  output logic                    tick_done_o
);

  logic [5:0] neuron_count_q;
  logic [8:0] edge_count_q;
  logic [4:0] input_base_q, left_base_q, right_base_q;
  logic       wr;
  reg_e       ridx;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neuron_count_q <= 6'd32;
      edge_count_q   <= 9'd0;
      input_base_q   <= 5'd0;
      left_base_q    <= 5'd10;
      right_base_q   <= 5'd20;
    end else if (wr) begin
      unique case (ridx)
        REG_NEURON_COUNT: neuron_count_q <= pwdata[5:0];
        REG_EDGE_COUNT:   edge_count_q   <= pwdata[8:0];
        REG_INPUT_BASE:   input_base_q   <= pwdata[4:0];
        REG_LEFT_BASE:    left_base_q    <= pwdata[4:0];
        REG_RIGHT_BASE:   right_base_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_NEURON_COUNT: prdata = 32'(neuron_count_q);
      REG_EDGE_COUNT:   prdata = 32'(edge_count_q);
      REG_INPUT_BASE:   prdata = 32'(input_base_q);
      REG_LEFT_BASE:    prdata = 32'(left_base_q);
      REG_RIGHT_BASE:   prdata = 32'(right_base_q);
      default:          prdata = '0;
    endcase
  end

  sont_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .neuron_count_i (neuron_count_q),
    .edge_count_i   (edge_count_q),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sont_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .slot_i           (slot_i),
    .period_in_i      (period_in_i),
    .spike_value_in_i (spike_value_in_i),
    .phase_in_i       (phase_in_i),
    .source_in_i      (source_in_i),
    .target_in_i      (target_in_i),
    .weight_in_i      (weight_in_i),
    .drive_in_i       (drive_in_i),
    .input_base_i     (input_base_q),
    .left_base_i      (left_base_q),
    .right_base_i     (right_base_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_sum_o       (left_sum_o),
    .right_sum_o      (right_sum_o),
    .tick_done_o      (tick_done_o)
  );

endmodule

`default_nettype wire

### rtl/sont_ctrl.sv
// Controller of the oscillator network tick: sequences neuron, edge,
// drive and group-sum passes. Uses sont_pkg.
`default_nettype none

module sont_ctrl
  import sont_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [5:0]        neuron_count_i,
  input  wire logic [8:0]        edge_count_i,
  input  sts_t                   sts_i,
  output cmd_t                   cmd_o
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  nn, ne;
  logic              accept;

  always_comb begin
    nn = (neuron_count_i > 6'(NEURONS)) ? IDX_W'(NEURONS) : IDX_W'(neuron_count_i);
    ne = (edge_count_i > 9'(EDGES)) ? IDX_W'(EDGES) : IDX_W'(edge_count_i);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (func_i == FUNC_TICK) begin
            if (nn != '0) state_d = ST_N_RD;
            else if (ne != '0) state_d = ST_E_RD;
            else state_d = ST_D_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_N_RD: state_d = ST_N_WR;
      ST_N_WR: begin
        if (idx_q == nn - 1'b1) begin
          idx_d   = '0;
          state_d = (ne != '0) ? ST_E_RD : ST_D_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_N_RD;
        end
      end
      ST_E_RD:  state_d = ST_E_OP;
      ST_E_OP:  state_d = ST_E_MUL;
      ST_E_MUL: state_d = ST_E_WR;
      ST_E_WR: begin
        if (idx_q == ne - 1'b1) begin
          idx_d   = '0;
          state_d = ST_D_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_E_RD;
        end
      end
      ST_D_RD: state_d = ST_D_WR;
      ST_D_WR: begin
        if (idx_q == IDX_W'(GROUP - 1)) begin
          idx_d   = '0;
          state_d = ST_S_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_D_RD;
        end
      end
      ST_S_RD: state_d = ST_S_ACC;
      ST_S_ACC: begin
        if (idx_q == IDX_W'(2 * GROUP - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = state_q;
    cmd_o.idx      = idx_q;
    cmd_o.accept   = accept;
    cmd_o.out_load = (state_q == ST_DONE) && !sts_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_edge_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_WR |-> idx_q < ne) else $error("edge index past count");
  a_neuron_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_N_WR |-> idx_q < nn) else $error("neuron index past count");
  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !sts_i.out_busy) |=> state_q == ST_IDLE)
    else $error("done state stuck");
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i != FUNC_TICK) |=> state_q == ST_DONE)
    else $error("load word not finished at once");
`endif

endmodule

`default_nettype wire

### rtl/sont_dp.sv
// Datapath of the oscillator network tick: neuron and edge memories,
// update arithmetic, group sums and output register. Uses sont_pkg.
`default_nettype none

module sont_dp
  import sont_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [7:0]         slot_i,
  input  wire logic [11:0]        period_in_i,
  input  wire logic signed [11:0] spike_value_in_i,
  input  wire logic [11:0]        phase_in_i,
  input  wire logic [4:0]         source_in_i,
  input  wire logic [4:0]         target_in_i,
  input  wire logic signed [11:0] weight_in_i,
  input  wire logic [2:0]         drive_in_i,
  input  wire logic [4:0]         input_base_i,
  input  wire logic [4:0]         left_base_i,
  input  wire logic [4:0]         right_base_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [14:0]      left_sum_o,
  output logic signed [14:0]      right_sum_o,
  output logic                    tick_done_o
);

  logic [11:0]        phase_mem  [NEURONS];
  logic [11:0]        period_mem [NEURONS];
  logic signed [11:0] spike_mem  [NEURONS];
  logic signed [11:0] out_mem    [NEURONS];
  logic signed [31:0] acc_mem    [NEURONS];
  logic [NI_W-1:0]    src_mem    [EDGES];
  logic [NI_W-1:0]    dst_mem    [EDGES];
  logic signed [11:0] wgt_mem    [EDGES];

  logic [NEURONS-1:0] nv_q;
  logic               pv_q, ov_q, av_q;
  logic [11:0]        phase_rd_q, period_rd_q;
  logic signed [11:0] spike_rd_q, out_rd_q, wgt_rd_q;
  logic signed [31:0] acc_rd_q;
  logic [NI_W-1:0]    src_rd_q, dst_rd_q;
  logic signed [23:0] prod_q;
  logic [2:0]         drive_q;
  logic               tick_q;
  logic               ok_q;
  logic signed [15:0] lsum_q, rsum_q;
  logic               out_valid_q;
  logic signed [14:0] left_q, right_q;
  logic               done_q;

  logic [11:0]        phase_eff;
  logic signed [11:0] out_eff;
  logic signed [31:0] acc_eff;
  logic [NI_W-1:0]    ni;
  logic [EI_W-1:0]    ei;
  logic [NI_W:0]      drv_a, sum_a;
  logic [GI_W-1:0]    gi;
  logic               is_right;
  logic [GI_W-1:0]    goff;
  logic               nload, eload;
  logic signed [33:0] p;
  logic               fire;
  logic [11:0]        phase_new;
  logic signed [11:0] out_new;
  logic signed [31:0] acc_edge, acc_drive;

  assign phase_eff = pv_q ? phase_rd_q : '0;
  assign out_eff   = ov_q ? out_rd_q : '0;
  assign acc_eff   = av_q ? acc_rd_q : '0;
  assign ni        = cmd_i.idx[NI_W-1:0];
  assign ei        = cmd_i.idx[EI_W-1:0];
  assign gi        = cmd_i.idx[GI_W-1:0];
  assign drv_a     = {1'b0, input_base_i} + (NI_W+1)'(gi);
  assign is_right  = gi >= GI_W'(GROUP);
  assign goff      = is_right ? gi - GI_W'(GROUP) : gi;
  assign sum_a     = (is_right ? {1'b0, right_base_i} : {1'b0, left_base_i})
                     + (NI_W+1)'(goff);
  assign nload     = cmd_i.accept && (func_i == FUNC_LOAD_NEURON) &&
                     (slot_i[7:NI_W] == '0);
  assign eload     = cmd_i.accept && (func_i == FUNC_LOAD_EDGE);

  always_comb begin
    p = $signed({22'b0, phase_eff}) + 34'(acc_eff) + 34'sd1;
    fire = p >= $signed({22'b0, period_rd_q});
    if (fire) begin
      out_new   = spike_rd_q;
      phase_new = '0;
    end else begin
      out_new   = '0;
      phase_new = p[33] ? 12'd0 : p[11:0];
    end
    acc_edge  = sat32(34'(acc_eff) + 34'(prod_q));
    acc_drive = sat32(34'(acc_eff) + $signed({31'b0, drive_q}));
  end

  // neuron parameters
  always_ff @(posedge clk_i) begin
    if (nload) begin
      period_mem[slot_i[NI_W-1:0]] <= period_in_i;
      spike_mem[slot_i[NI_W-1:0]]  <= spike_value_in_i;
    end
    period_rd_q <= period_mem[ni];
    spike_rd_q  <= spike_mem[ni];
  end

  always_ff @(posedge clk_i) begin
    if (nload) phase_mem[slot_i[NI_W-1:0]] <= phase_in_i;
    else if (cmd_i.op == ST_N_WR) phase_mem[ni] <= phase_new;
    phase_rd_q <= phase_mem[ni];
  end

  always_ff @(posedge clk_i) begin
    if (nload) out_mem[slot_i[NI_W-1:0]] <= '0;
    else if (cmd_i.op == ST_N_WR) out_mem[ni] <= out_new;
    out_rd_q <= out_mem[(cmd_i.op == ST_E_OP) ? src_rd_q : sum_a[NI_W-1:0]];
  end

  // target word held through the multiply step
  always_ff @(posedge clk_i) begin
    if (nload) acc_mem[slot_i[NI_W-1:0]] <= '0;
    else if (cmd_i.op == ST_N_WR) acc_mem[ni] <= '0;
    else if (cmd_i.op == ST_E_WR) acc_mem[dst_rd_q] <= acc_edge;
    else if (cmd_i.op == ST_D_WR && ok_q) acc_mem[drv_a[NI_W-1:0]] <= acc_drive;
    priority case (cmd_i.op)
      ST_E_OP:  acc_rd_q <= acc_mem[dst_rd_q];
      ST_E_MUL: acc_rd_q <= acc_rd_q;
      ST_D_RD:  acc_rd_q <= acc_mem[drv_a[NI_W-1:0]];
      default:  acc_rd_q <= acc_mem[ni];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (eload) begin
      src_mem[slot_i[EI_W-1:0]] <= source_in_i;
      dst_mem[slot_i[EI_W-1:0]] <= target_in_i;
      wgt_mem[slot_i[EI_W-1:0]] <= weight_in_i;
    end
    if (cmd_i.op == ST_E_RD) begin
      src_rd_q <= src_mem[ei];
      dst_rd_q <= dst_mem[ei];
      wgt_rd_q <= wgt_mem[ei];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
      pv_q <= 1'b0;
      ov_q <= 1'b0;
      av_q <= 1'b0;
    end else begin
      if (nload) nv_q[slot_i[NI_W-1:0]] <= 1'b1;
      else if (cmd_i.op == ST_N_WR) nv_q[ni] <= 1'b1;
      pv_q <= nv_q[ni];
      ov_q <= nv_q[(cmd_i.op == ST_E_OP) ? src_rd_q : sum_a[NI_W-1:0]];
      priority case (cmd_i.op)
        ST_E_OP:  av_q <= nv_q[dst_rd_q];
        ST_E_MUL: av_q <= av_q;
        ST_D_RD:  av_q <= nv_q[drv_a[NI_W-1:0]];
        default:  av_q <= nv_q[ni];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      drive_q <= drive_in_i;
      tick_q  <= (func_i == FUNC_TICK);
      lsum_q  <= '0;
      rsum_q  <= '0;
    end
    if (cmd_i.op == ST_E_MUL) prod_q <= wgt_rd_q * out_eff;
    if (cmd_i.op == ST_D_RD) ok_q <= !drv_a[NI_W];
    if (cmd_i.op == ST_S_RD) ok_q <= !sum_a[NI_W];
    if (cmd_i.op == ST_S_ACC && ok_q) begin
      if (is_right) rsum_q <= rsum_q + 16'(out_eff);
      else lsum_q <= lsum_q + 16'(out_eff);
    end
    if (cmd_i.out_load) begin
      left_q  <= tick_q ? lsum_q[14:0] : '0;
      right_q <= tick_q ? rsum_q[14:0] : '0;
      done_q  <= tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign left_sum_o     = left_q;
  assign right_sum_o    = right_q;
  assign tick_done_o    = done_q;

endmodule

`default_nettype wire
